>>> rtl/bpsc_pkg.sv
// shared types and constants for the blower pi speed command block
package bpsc_pkg;

    // measurement selector carried in the input tuser
    typedef enum logic [2:0] {
        MODE_SPEED       = 3'd0,
        MODE_PAT_PRESS   = 3'd1,
        MODE_VALVE_PRESS = 3'd2,
        MODE_INSP_FLOW   = 3'd3,
        MODE_EXH_FLOW    = 3'd4,
        MODE_INT_PRESS   = 3'd5
    } t_mode;

    // register indexes, taken from paddr[3:2]
    localparam logic [1:0] REG_INTEG_MIN = 2'd0;
    localparam logic [1:0] REG_INTEG_MAX = 2'd1;
    localparam logic [1:0] REG_OFF_CODE  = 2'd2;

    localparam logic [16:0] INTEG_MAX_RST = 17'd30000;

    // x/1000 = (x>>3)/125, /125 as ceil(2^35/125) reciprocal, exact below 2^30
    localparam logic [28:0] RECIP_125    = 29'd274877907;
    // x/10 = (x>>1)/5, /5 as ceil(2^24/5) reciprocal, exact below 2^22
    localparam logic [21:0] RECIP_5      = 22'd3355444;
    // full scale = integral_max/10, ceil(2^20/10) reciprocal, exact below 2^17
    localparam logic [16:0] RECIP_10     = 17'd104858;

    localparam logic signed [14:0] LOW_PRESS_OFFSET = 15'sd2600;
    localparam logic signed [15:0] LOW_PRESS_LIMIT  = 16'sd10;

    // one input word, unpacked
    typedef struct packed {
        logic [15:0]        kp;
        logic [15:0]        ki;
        logic [15:0]        setpoint;
        logic [2:0]         mode;
        logic [15:0]        speed_meas;
        logic signed [15:0] patient_pressure;
        logic signed [15:0] valve_pressure;
        logic signed [15:0] insp_flow;
        logic signed [15:0] exh_flow;
        logic signed [15:0] internal_pressure;
        logic               vent_enabled;
        logic               stop_request;
    } t_item;

endpackage

>>> rtl/blower_pi_speed_command.sv
// pi speed command for a ventilator blower, eight stage pipeline with apb registers
//
// channel   | dir | fields
// ----------+-----+---------------------------------------------------------------
// s_axis    | in  | gains, setpoint, six measurements, vent and stop flags; mode in tuser
// m_axis    | out | blower_command, brake_release
// apb       | in  | integral_min (0x0), integral_max (0x4), off_code (0x8)
//
// a word passes through stages s0 to s7 in order; one word per cycle is sustained while m_axis is ready
// the integral loop closes in stage 4 alone (one add, two compares), so words follow back to back
// reset clears the stage valid bits, the integral and the registers to their reset values
// a stall on m_axis holds the stages that are full; empty stages keep filling
module blower_pi_speed_command (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // input words
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // kp[15:0] ki[31:16] setpoint[47:32] speed_meas[63:48] patient_pressure[79:64]
    // valve_pressure[95:80] insp_flow[111:96] exh_flow[127:112]
    // internal_pressure[143:128] vent_enabled[144] stop_request[145] zero[151:146]
    input  logic [151:0] s_axis_tdata,
    // mode[2:0]
    input  logic [2:0]   s_axis_tuser,
    // result words
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // blower_command[15:0] brake_release[16] zero[23:17]
    output logic [23:0]  m_axis_tdata,
    // register port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int NSTG = 8;

    // registers
    logic signed [17:0] r_integ_min;
    logic [16:0]        r_integ_max;
    logic [15:0]        r_off_code;
    logic [13:0]        r_full;
    logic signed [14:0] r_cap;

    // pipeline control
    logic [NSTG-1:0]    r_vld;
    logic [NSTG:0]      rdy;
    logic signed [17:0] r_integ;
    logic signed [17:0] n_integ;

    // stage registers
    bpsc_pkg::t_item    r_s0_item;
    logic signed [34:0] r_s1_kprod, r_s1_iprod;
    logic               r_s1_cap_en, r_s1_stop;
    logic [29:0]        r_s2_kn, r_s2_in;
    logic               r_s2_kneg, r_s2_ineg, r_s2_cap_en, r_s2_stop;
    logic [22:0]        r_s3_kq, r_s3_iq;
    logic               r_s3_kneg, r_s3_ineg, r_s3_cap_en, r_s3_stop;
    logic signed [23:0] r_s4_prop;
    logic signed [17:0] r_s4_integ;
    logic               r_s4_cap_en, r_s4_stop;
    logic [21:0]        r_s5_half;
    logic               r_s5_neg, r_s5_cap_en, r_s5_stop;
    logic [19:0]        r_s6_q10;
    logic               r_s6_neg, r_s6_cap_en, r_s6_stop;
    logic [15:0]        r_s7_cmd;
    logic               r_s7_brake;

    // combinational values
    logic               cfg_wr;
    logic [33:0]        full_prod;
    bpsc_pkg::t_item    in_item;
    logic signed [17:0] err;
    logic signed [17:0] meas_s;
    logic signed [34:0] kprod, iprod;
    logic signed [34:0] kmag, imag;
    logic [58:0]        kq_prod, iq_prod;
    logic signed [24:0] integ_sum;
    logic signed [24:0] integ_lo;
    logic signed [24:0] integ_clamped;
    logic signed [24:0] integ_delta;
    logic signed [24:0] pi_sum;
    logic signed [24:0] pi_mag;
    logic [43:0]        q10_prod;
    logic signed [20:0] cmd0, cmd1, cap_x, full_x;
    logic [13:0]        cmd2;
    logic [13:0]        cmd_inv;
    logic [15:0]        n_cmd;

    function automatic logic signed [34:0] kprod_neg(input logic signed [34:0] v);
        kprod_neg = v[34] ? (35'sd0 - v) : v;
    endfunction

    // register port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_comb begin
        case (paddr[3:2])
            bpsc_pkg::REG_INTEG_MIN: prdata = {{14{r_integ_min[17]}}, r_integ_min};
            bpsc_pkg::REG_INTEG_MAX: prdata = {15'd0, r_integ_max};
            bpsc_pkg::REG_OFF_CODE:  prdata = {16'd0, r_off_code};
            default:                 prdata = 32'd0;
        endcase
    end

    // full command scale and low pressure cap follow integral_max
    assign full_prod = 34'(r_integ_max) * 34'(bpsc_pkg::RECIP_10);

    always_ff @(posedge i_clk) begin
        r_full <= full_prod[33:20];
        r_cap  <= $signed({1'b0, full_prod[33:20]}) - bpsc_pkg::LOW_PRESS_OFFSET;
    end

    // stage handshake: a stage takes a word when it is empty or its word moves on
    always_comb begin
        rdy[NSTG] = m_axis_tready;
        for (int i = NSTG - 1; i >= 0; i--) begin
            rdy[i] = !r_vld[i] || rdy[i+1];
        end
    end

    assign s_axis_tready = rdy[0];
    assign m_axis_tvalid = r_vld[NSTG-1];
    assign m_axis_tdata  = {7'd0, r_s7_brake, r_s7_cmd};

    // unpack the input word
    always_comb begin
        in_item.kp                = s_axis_tdata[15:0];
        in_item.ki                = s_axis_tdata[31:16];
        in_item.setpoint          = s_axis_tdata[47:32];
        in_item.speed_meas        = s_axis_tdata[63:48];
        in_item.patient_pressure  = s_axis_tdata[79:64];
        in_item.valve_pressure    = s_axis_tdata[95:80];
        in_item.insp_flow         = s_axis_tdata[111:96];
        in_item.exh_flow          = s_axis_tdata[127:112];
        in_item.internal_pressure = s_axis_tdata[143:128];
        in_item.vent_enabled      = s_axis_tdata[144];
        in_item.stop_request      = s_axis_tdata[145];
        in_item.mode              = s_axis_tuser;
    end

    // stage 1: pick the measurement, form the error and both products
    always_comb begin
        case (bpsc_pkg::t_mode'(r_s0_item.mode))
            bpsc_pkg::MODE_SPEED:       meas_s = $signed({2'b00, r_s0_item.speed_meas});
            bpsc_pkg::MODE_PAT_PRESS:   meas_s = 18'(r_s0_item.patient_pressure);
            bpsc_pkg::MODE_VALVE_PRESS: meas_s = 18'(r_s0_item.valve_pressure);
            bpsc_pkg::MODE_INSP_FLOW:   meas_s = 18'(r_s0_item.insp_flow);
            bpsc_pkg::MODE_EXH_FLOW:    meas_s = 18'(r_s0_item.exh_flow);
            bpsc_pkg::MODE_INT_PRESS:   meas_s = 18'(r_s0_item.internal_pressure);
            default:                    meas_s = $signed({2'b00, r_s0_item.setpoint});
        endcase
        err   = $signed({2'b00, r_s0_item.setpoint}) - meas_s;
        kprod = $signed({1'b0, r_s0_item.kp}) * err;
        iprod = $signed({1'b0, r_s0_item.ki}) * err;
    end

    // stage 2: magnitudes, prescaled by eight for the divide by 1000
    assign kmag = kprod_neg(r_s1_kprod);
    assign imag = kprod_neg(r_s1_iprod);

    // stage 3: divide by 125 through the reciprocal
    assign kq_prod = 59'(r_s2_kn) * 59'(bpsc_pkg::RECIP_125);
    assign iq_prod = 59'(r_s2_in) * 59'(bpsc_pkg::RECIP_125);

    // stage 4: integral update, clamp with the lower limit first
    always_comb begin
        integ_delta   = r_s3_ineg ? -$signed({2'b00, r_s3_iq}) : $signed({2'b00, r_s3_iq});
        integ_sum     = 25'(r_integ) + integ_delta;
        integ_lo      = (integ_sum < 25'(r_integ_min)) ? 25'(r_integ_min) : integ_sum;
        integ_clamped = (integ_lo > $signed({8'd0, r_integ_max}))
                      ? $signed({8'd0, r_integ_max}) : integ_lo;
        n_integ       = r_s3_stop ? 18'sd0 : integ_clamped[17:0];
    end

    // stage 5: p plus i, magnitude halved for the divide by 10
    always_comb begin
        pi_sum = 25'(r_s4_prop) + 25'(r_s4_integ);
        pi_mag = pi_sum[24] ? (25'sd0 - pi_sum) : pi_sum;
    end

    // stage 6: divide by 5 through the reciprocal
    assign q10_prod = 44'(r_s5_half) * 44'(bpsc_pkg::RECIP_5);

    // stage 7: low pressure cap, clamp to full scale, invert, stop override
    always_comb begin
        cmd0   = r_s6_neg ? -$signed({1'b0, r_s6_q10}) : $signed({1'b0, r_s6_q10});
        cap_x  = 21'(r_cap);
        full_x = $signed({7'd0, r_full});
        cmd1   = (r_s6_cap_en && (cmd0 >= cap_x)) ? cap_x : cmd0;
        if (cmd1[20]) begin
            cmd2 = 14'd0;
        end else if (cmd1 > full_x) begin
            cmd2 = r_full;
        end else begin
            cmd2 = cmd1[13:0];
        end
        cmd_inv = r_full - cmd2;
        n_cmd   = r_s6_stop ? r_off_code : {2'b00, cmd_inv};
    end

    // control state: registers, valid bits and the integral
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ_min <= 18'sd0;
            r_integ_max <= bpsc_pkg::INTEG_MAX_RST;
            r_off_code  <= 16'd0;
            r_vld       <= '0;
            r_integ     <= 18'sd0;
        end else begin
            if (cfg_wr) begin
                case (paddr[3:2])
                    bpsc_pkg::REG_INTEG_MIN: r_integ_min <= pwdata[17:0];
                    bpsc_pkg::REG_INTEG_MAX: r_integ_max <= pwdata[16:0];
                    bpsc_pkg::REG_OFF_CODE:  r_off_code  <= pwdata[15:0];
                    default: ;
                endcase
            end
            if (rdy[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int i = 1; i < NSTG; i++) begin
                if (rdy[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
            if (r_vld[3] && rdy[4]) begin
                r_integ <= n_integ;
            end
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_s0_item <= in_item;
        end
        if (rdy[1]) begin
            r_s1_kprod  <= kprod;
            r_s1_iprod  <= iprod;
            r_s1_cap_en <= r_s0_item.vent_enabled
                           && (r_s0_item.patient_pressure <= bpsc_pkg::LOW_PRESS_LIMIT)
                           && (bpsc_pkg::t_mode'(r_s0_item.mode) != bpsc_pkg::MODE_INSP_FLOW);
            r_s1_stop   <= r_s0_item.stop_request || (r_s0_item.setpoint == 16'd0);
        end
        if (rdy[2]) begin
            r_s2_kn     <= kmag[32:3];
            r_s2_in     <= imag[32:3];
            r_s2_kneg   <= r_s1_kprod[34];
            r_s2_ineg   <= r_s1_iprod[34];
            r_s2_cap_en <= r_s1_cap_en;
            r_s2_stop   <= r_s1_stop;
        end
        if (rdy[3]) begin
            r_s3_kq     <= kq_prod[57:35];
            r_s3_iq     <= iq_prod[57:35];
            r_s3_kneg   <= r_s2_kneg;
            r_s3_ineg   <= r_s2_ineg;
            r_s3_cap_en <= r_s2_cap_en;
            r_s3_stop   <= r_s2_stop;
        end
        if (rdy[4]) begin
            r_s4_prop   <= r_s3_kneg ? -$signed({1'b0, r_s3_kq}) : $signed({1'b0, r_s3_kq});
            r_s4_integ  <= integ_clamped[17:0];
            r_s4_cap_en <= r_s3_cap_en;
            r_s4_stop   <= r_s3_stop;
        end
        if (rdy[5]) begin
            r_s5_half   <= pi_mag[22:1];
            r_s5_neg    <= pi_sum[24];
            r_s5_cap_en <= r_s4_cap_en;
            r_s5_stop   <= r_s4_stop;
        end
        if (rdy[6]) begin
            r_s6_q10    <= q10_prod[43:24];
            r_s6_neg    <= r_s5_neg;
            r_s6_cap_en <= r_s5_cap_en;
            r_s6_stop   <= r_s5_stop;
        end
        if (rdy[7]) begin
            r_s7_cmd    <= n_cmd;
            r_s7_brake  <= (n_cmd != r_off_code);
        end
    end

endmodule
